@@ src/lcc_pkg.sv @@
// lcc_pkg: sizes, register indexes and controller/datapath interface types
// for the laser column centroid block. No dependencies.
package lcc_pkg;

  // Longest column handled; the row counter saturates here.
  localparam int COLUMN_ROWS = 1024;

  // Row counter holds 0 .. COLUMN_ROWS inclusive.
  localparam int ROW_W     = $clog2(COLUMN_ROWS + 1);
  // Bits of a row that can still count (0 .. COLUMN_ROWS-1).
  localparam int ROW_IDX_W = $clog2(COLUMN_ROWS);
  localparam int PIX_W     = 8;
  // At most COLUMN_ROWS pixels count, each up to 255.
  localparam int ISUM_W    = PIX_W + ROW_W;
  // Weighted sum never exceeds (largest counted row) * intensity sum.
  localparam int WSUM_W    = ROW_IDX_W + ISUM_W;
  localparam int FRAC_W    = 8;
  // Dividend of the centroid division, also its quotient register.
  localparam int DVD_W     = WSUM_W + FRAC_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int RES_W     = 18;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROI_W      = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_END   = 2'd2;

  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd150;
  localparam logic [ROI_W-1:0] ROI_START_RESET = 11'd0;
  localparam logic [ROI_W-1:0] ROI_END_RESET   = 11'd1024;

  // Common width for row / window compares.
  localparam int CMP_W = (ROW_W > ROI_W) ? ROW_W : ROI_W;

  typedef struct packed {
    logic acc_en;    // pixel transaction: update row counter and sums
    logic col_done;  // column end: load divider, clear sums
    logic div_step;  // one restoring division step
    logic finish;    // capture the result
  } lcc_cmd_t;

  typedef struct packed {
    logic div_done;  // last division step is being done
  } lcc_status_t;

endpackage

@@ src/lcc_ctrl.sv @@
// lcc_ctrl: controller of the laser column centroid block; handshakes and
// sequencing of the divider. Depends on lcc_pkg.
module lcc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 column_end_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lcc_pkg::lcc_status_t status_i,
  output lcc_pkg::lcc_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       in_fire;

  // Pixels keep flowing; only a column end waits for the divider.
  assign in_ready_o  = (state_q == ST_IDLE) || !column_end_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d         = state_q;
    cmd_o.acc_en    = in_fire;
    cmd_o.col_done  = in_fire && column_end_i;
    cmd_o.div_step  = 1'b0;
    cmd_o.finish    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && column_end_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/lcc_datapath.sv @@
// lcc_datapath: configuration registers, row counter, accumulators and the
// bit-serial centroid divider. Depends on lcc_pkg.
module lcc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lcc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [lcc_pkg::PIX_W-1:0]         pixel_value_i,
  input  lcc_pkg::lcc_cmd_t                 cmd_i,
  output lcc_pkg::lcc_status_t              status_o,
  output logic [lcc_pkg::RES_W-1:0]         centroid_q8_o,
  output logic                              found_o
);

  logic [lcc_pkg::PIX_W-1:0]  thr_q;
  logic [lcc_pkg::ROI_W-1:0]  roi_start_q, roi_end_q;

  logic [lcc_pkg::ROW_W-1:0]  row_q, row_d;
  logic [lcc_pkg::WSUM_W-1:0] wsum_q, wsum_d;
  logic [lcc_pkg::ISUM_W-1:0] isum_q, isum_d;

  logic [lcc_pkg::DVD_W-1:0]  dq_q;
  logic [lcc_pkg::ISUM_W-1:0] rem_q, divisor_q;
  logic [lcc_pkg::DCNT_W-1:0] cnt_q;

  logic [lcc_pkg::CMP_W-1:0]       row_c;
  logic                            counts;
  logic [lcc_pkg::ROW_W+lcc_pkg::PIX_W-1:0] prod;
  logic [lcc_pkg::ISUM_W:0]        rem_sh, diff;
  logic                            ge;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= lcc_pkg::THRESHOLD_RESET;
      roi_start_q <= lcc_pkg::ROI_START_RESET;
      roi_end_q   <= lcc_pkg::ROI_END_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcc_pkg::CFG_THRESHOLD: thr_q       <= cfg_data_i[lcc_pkg::PIX_W-1:0];
        lcc_pkg::CFG_ROI_START: roi_start_q <= cfg_data_i[lcc_pkg::ROI_W-1:0];
        lcc_pkg::CFG_ROI_END:   roi_end_q   <= cfg_data_i[lcc_pkg::ROI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Accumulation, one pixel per cycle
  assign row_c  = lcc_pkg::CMP_W'(row_q);
  assign counts = (row_q != lcc_pkg::ROW_W'(lcc_pkg::COLUMN_ROWS))
                  && (row_c >= lcc_pkg::CMP_W'(roi_start_q))
                  && (row_c <  lcc_pkg::CMP_W'(roi_end_q))
                  && (pixel_value_i > thr_q);
  assign prod   = row_q * pixel_value_i;

  always_comb begin
    wsum_d = wsum_q;
    isum_d = isum_q;
    row_d  = row_q;
    if (counts) begin
      wsum_d = wsum_q + lcc_pkg::WSUM_W'(prod);
      isum_d = isum_q + lcc_pkg::ISUM_W'(pixel_value_i);
    end
    if (row_q != lcc_pkg::ROW_W'(lcc_pkg::COLUMN_ROWS)) begin
      row_d = row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      wsum_q <= '0;
      isum_q <= '0;
    end else if (cmd_i.col_done) begin
      row_q  <= '0;
      wsum_q <= '0;
      isum_q <= '0;
    end else if (cmd_i.acc_en) begin
      row_q  <= row_d;
      wsum_q <= wsum_d;
      isum_q <= isum_d;
    end
  end

  // Restoring division, one quotient bit per step; dq_q shifts the
  // dividend out at the top and the quotient in at the bottom.
  assign rem_sh = {rem_q, dq_q[lcc_pkg::DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, divisor_q});
  assign diff   = rem_sh - {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_done) begin
      dq_q      <= {wsum_d, {lcc_pkg::FRAC_W{1'b0}}};
      divisor_q <= isum_d;
      rem_q     <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= {dq_q[lcc_pkg::DVD_W-2:0], ge};
      rem_q <= ge ? diff[lcc_pkg::ISUM_W-1:0] : rem_sh[lcc_pkg::ISUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.col_done) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign status_o.div_done =
    (cnt_q == lcc_pkg::DCNT_W'(lcc_pkg::DIV_STEPS - 1));

  // Result register; quotient saturates, empty column gives zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_o <= (divisor_q != '0);
      if (divisor_q == '0) begin
        centroid_q8_o <= '0;
      end else if (dq_q[lcc_pkg::DVD_W-1:lcc_pkg::RES_W] != '0) begin
        centroid_q8_o <= '1;
      end else begin
        centroid_q8_o <= dq_q[lcc_pkg::RES_W-1:0];
      end
    end
  end

endmodule

@@ src/laser_column_centroid.sv @@
// laser_column_centroid: top level, thresholded centre of gravity of one
// image column. Depends on lcc_pkg, lcc_ctrl and lcc_datapath.

// Pixels of a column enter top to bottom, one transaction per clock, and are
// counted when their row lies in [roi_start, roi_end) and their value is
// strictly above intensity_threshold; the row counter saturates at
// COLUMN_ROWS and a pixel on that row never counts. The transaction that
// carries column_end is counted too and then starts the division
// floor(weighted_sum * 256 / intensity_sum), done by a restoring divider one
// quotient bit per clock: the result is captured after DVD_W = 37 division
// steps and is held until taken, saturating at all ones, or 0 with found_o
// low for an empty column. The next column's pixels stream in during the
// division; only its column end waits (in_ready_o low) until the previous
// result has been taken, so columns of 40 pixels or more run at one pixel per
// cycle if each result is taken at once. Configuration writes are always
// accepted and should be made with the block idle;
// index 0 is the threshold, 1 roi_start, 2 roi_end, others are ignored.
module laser_column_centroid (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lcc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // pixel channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lcc_pkg::PIX_W-1:0]      pixel_value_i,
  input  logic                           column_end_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lcc_pkg::RES_W-1:0]      centroid_q8_o,
  output logic                           found_o
);

  lcc_pkg::lcc_cmd_t    cmd;
  lcc_pkg::lcc_status_t status;

  // Register writes never stall.
  assign cfg_ready_o = 1'b1;

  lcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .column_end_i(column_end_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lcc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_value_i(pixel_value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .centroid_q8_o(centroid_q8_o),
    .found_o      (found_o)
  );

  // Backpressure only ever holds back a column end.
  a_ready_only_col_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> column_end_i)
    else $error("input stalled without a column end on the port");

  // A column end is only taken with no result pending, and none follows at once.
  a_col_end_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && column_end_i) |-> !out_valid_o ##1 !out_valid_o)
    else $error("column end taken while a result was pending");

  // An empty column reports a zero centroid.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (centroid_q8_o == '0))
    else $error("non-zero centroid without a counted pixel");

  // Division and capture never overlap a new command to load the divider.
  a_no_load_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step || cmd.finish) |-> !cmd.col_done)
    else $error("divider reloaded while busy");

endmodule
